// File: design/bae_pkg.sv
// ============================================================================
// bae_pkg: shared types and constants of the block average error estimator
// Holds the sequencer states, the shared unit's operation codes and the
// control bundle passed from the sequencer to the iterative unit.
// ============================================================================
package bae_pkg;

  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 16'd100;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } iter_ctrl_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_DIV_A,
    ST_DIV_B,
    ST_UPD_A,
    ST_UPD_B,
    ST_MEAN,
    ST_MSQ,
    ST_VAR,
    ST_VDIV,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

// File: design/block_average_error_estimator_core.sv
// ============================================================================
// block_average_error_estimator_core: blocking mean and standard error
// Accumulates samples into blocks and, at each block close, reports the
// progressive means and blocking standard errors of the sample and of its
// squared deviation from one half.
// ============================================================================
//
//  Channel  Direction  Ports                          Transfer
//  in       input      in_valid/in_ready, in_sample   one sample
//  out      output     out_valid/out_ready, out_*     one result per block
//  cfg      input      cfg_valid/cfg_ready, cfg_data  block length write
//
// A sample is taken every cycle while a block fills. When a block closes,
// the shared divide and square root unit runs, and in_ready is low during
// that time. The result waits in an output register, so filling of the
// next block goes on while it is not taken. Reset is synchronous and
// active low; it restores a block length of 100 and clears all sums and
// counts.
//
module block_average_error_estimator_core #(
  parameter int SAMPLE_BITS      = 16,
  parameter int BLOCK_COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [BLOCK_COUNT_BITS-1:0]   out_block_index,
  output logic [SAMPLE_BITS-1:0]        out_progressive_mean,
  output logic [SAMPLE_BITS-1:0]        out_mean_error,
  output logic [SAMPLE_BITS-2:0]        out_progressive_devsq_mean,
  output logic [SAMPLE_BITS-1:0]        out_devsq_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bae_pkg::LEN_BITS-1:0]  cfg_data
);
  import bae_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int C   = BLOCK_COUNT_BITS;
  localparam int VW  = (C > LEN_BITS) ? C : LEN_BITS;
  localparam int DW  = 2 * S + VW;
  localparam int BSW = S + LEN_BITS;
  localparam int BDW = 2 * S + LEN_BITS - 2;
  localparam int MSW = S + C;
  localparam int MQW = 2 * S + C;
  localparam int DSW = S - 1 + C;
  localparam int DQW = 2 * S - 2 + C;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;
  logic   sel_r, sel_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [LEN_BITS-1:0] block_len_r;
  logic [LEN_BITS-1:0] cnt_r, cnt_nxt;
  logic [BSW-1:0]      bsum_r, bsum_nxt;
  logic [BDW-1:0]      bdsq_r, bdsq_nxt;
  logic [C-1:0]        blocks_r, blocks_nxt;
  logic [MSW-1:0]      sum_m_r, sum_m_nxt;
  logic [MQW-1:0]      sumsq_m_r, sumsq_m_nxt;
  logic [DSW-1:0]      sum_d_r, sum_d_nxt;
  logic [DQW-1:0]      sumsq_d_r, sumsq_d_nxt;

  logic [S-1:0]   a_r, a_nxt;
  logic [S-2:0]   b_r, b_nxt;
  logic [S-1:0]   m_r, m_nxt;
  logic [2*S-1:0] q_r, q_nxt;
  logic [2*S-1:0] v_r, v_nxt;
  logic [S-1:0]   res_mean_r, res_mean_nxt;
  logic [S-1:0]   res_merr_r, res_merr_nxt;
  logic [S-2:0]   res_dmean_r, res_dmean_nxt;
  logic [S-1:0]   res_derr_r, res_derr_nxt;
  logic           out_load;

  logic [C-1:0] out_index_r;
  logic [S-1:0] out_mean_r, out_merr_r, out_derr_r;
  logic [S-2:0] out_dmean_r;

  iter_ctrl_t     ctrl;
  logic [DW-1:0]  dividend, quot;
  logic [VW-1:0]  divisor;
  logic           done;
  logic [S-1:0]   root;

  logic [LEN_BITS-1:0] len_eff, cnt_inc;
  logic [S-1:0]        dev, sq_op;
  logic [2*S-1:0]      sq;
  logic [MSW-1:0]      sum_sel;
  logic [MQW-1:0]      sumsq_sel;
  logic                sat;

  localparam logic [S-1:0] HALF = S'(1) << (S - 1);

  bae_iter_unit #(
    .SAMPLE_BITS (S),
    .DIV_W       (DW),
    .DVSR_W      (VW)
  ) u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .quotient (quot),
    .root     (root)
  );

  assign in_ready  = (state_r == ST_ACC);
  assign cfg_ready = 1'b1;
  assign len_eff   = (block_len_r == '0) ? LEN_BITS'(1) : block_len_r;
  assign cnt_inc   = cnt_r + 1'b1;
  assign dev       = (in_sample >= HALF) ? (in_sample - HALF) : (HALF - in_sample);
  assign sq        = (2 * S)'(sq_op) * (2 * S)'(sq_op);
  assign sum_sel   = sel_r ? MSW'(sum_d_r) : sum_m_r;
  assign sumsq_sel = sel_r ? MQW'(sumsq_d_r) : sumsq_m_r;
  assign sat       = (blocks_r == '1);

  always_comb begin
    state_nxt     = state_r;
    launched_nxt  = launched_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    ctrl.start    = 1'b0;
    ctrl.op       = OP_DIV;
    dividend      = '0;
    divisor       = '0;
    sq_op         = '0;
    cnt_nxt       = cnt_r;
    bsum_nxt      = bsum_r;
    bdsq_nxt      = bdsq_r;
    blocks_nxt    = blocks_r;
    sum_m_nxt     = sum_m_r;
    sumsq_m_nxt   = sumsq_m_r;
    sum_d_nxt     = sum_d_r;
    sumsq_d_nxt   = sumsq_d_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    m_nxt         = m_r;
    q_nxt         = q_r;
    v_nxt         = v_r;
    res_mean_nxt  = res_mean_r;
    res_merr_nxt  = res_merr_r;
    res_dmean_nxt = res_dmean_r;
    res_derr_nxt  = res_derr_r;

    case (state_r)
      ST_ACC: begin
        sq_op = dev;
        if (in_valid) begin
          cnt_nxt  = cnt_inc;
          bsum_nxt = bsum_r + BSW'(in_sample);
          bdsq_nxt = bdsq_r + BDW'(sq);
          if (cnt_inc >= len_eff) begin
            state_nxt = ST_DIV_A;
          end
        end
      end
      ST_DIV_A: begin
        dividend = DW'(bsum_r);
        divisor  = VW'(cnt_r);
        if (!launched_r) begin
          ctrl.start   = 1'b1;
          launched_nxt = 1'b1;
        end else if (done) begin
          launched_nxt = 1'b0;
          a_nxt        = quot[S-1:0];
          state_nxt    = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        dividend = DW'(bdsq_r);
        divisor  = VW'(cnt_r);
        if (!launched_r) begin
          ctrl.start   = 1'b1;
          launched_nxt = 1'b1;
        end else if (done) begin
          launched_nxt = 1'b0;
          b_nxt        = quot[2*S-2:S];
          state_nxt    = ST_UPD_A;
        end
      end
      ST_UPD_A: begin
        sq_op    = a_r;
        cnt_nxt  = '0;
        bsum_nxt = '0;
        bdsq_nxt = '0;
        if (!sat) begin
          sum_m_nxt   = sum_m_r + MSW'(a_r);
          sumsq_m_nxt = sumsq_m_r + MQW'(sq);
        end
        state_nxt = ST_UPD_B;
      end
      ST_UPD_B: begin
        sq_op = S'(b_r);
        if (!sat) begin
          sum_d_nxt   = sum_d_r + DSW'(b_r);
          sumsq_d_nxt = sumsq_d_r + DQW'(sq);
          blocks_nxt  = blocks_r + 1'b1;
        end
        sel_nxt   = 1'b0;
        state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        dividend = DW'(sum_sel);
        divisor  = VW'(blocks_r);
        if (!launched_r) begin
          ctrl.start   = 1'b1;
          launched_nxt = 1'b1;
        end else if (done) begin
          launched_nxt = 1'b0;
          m_nxt        = quot[S-1:0];
          if (sel_r) begin
            res_dmean_nxt = quot[S-2:0];
          end else begin
            res_mean_nxt = quot[S-1:0];
          end
          if (blocks_r > C'(1)) begin
            state_nxt = ST_MSQ;
          end else begin
            if (sel_r) begin
              res_derr_nxt = '0;
              state_nxt    = ST_OUT;
            end else begin
              res_merr_nxt = '0;
              sel_nxt      = 1'b1;
              state_nxt    = ST_MEAN;
            end
          end
        end
      end
      ST_MSQ: begin
        dividend = DW'(sumsq_sel);
        divisor  = VW'(blocks_r);
        if (!launched_r) begin
          ctrl.start   = 1'b1;
          launched_nxt = 1'b1;
        end else if (done) begin
          launched_nxt = 1'b0;
          q_nxt        = quot[2*S-1:0];
          state_nxt    = ST_VAR;
        end
      end
      ST_VAR: begin
        sq_op     = m_r;
        v_nxt     = (q_r > sq) ? (q_r - sq) : '0;
        state_nxt = ST_VDIV;
      end
      ST_VDIV: begin
        dividend = DW'(v_r);
        divisor  = VW'(blocks_r - 1'b1);
        if (!launched_r) begin
          ctrl.start   = 1'b1;
          launched_nxt = 1'b1;
        end else if (done) begin
          launched_nxt = 1'b0;
          v_nxt        = quot[2*S-1:0];
          state_nxt    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        ctrl.op  = OP_SQRT;
        dividend = {v_r, {VW{1'b0}}};
        if (!launched_r) begin
          ctrl.start   = 1'b1;
          launched_nxt = 1'b1;
        end else if (done) begin
          launched_nxt = 1'b0;
          if (sel_r) begin
            res_derr_nxt = root;
            state_nxt    = ST_OUT;
          end else begin
            res_merr_nxt = root;
            sel_nxt      = 1'b1;
            state_nxt    = ST_MEAN;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      launched_r  <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      block_len_r <= LEN_RESET;
      cnt_r       <= '0;
      bsum_r      <= '0;
      bdsq_r      <= '0;
      blocks_r    <= '0;
      sum_m_r     <= '0;
      sumsq_m_r   <= '0;
      sum_d_r     <= '0;
      sumsq_d_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        block_len_r <= cfg_data;
      end
      cnt_r     <= cnt_nxt;
      bsum_r    <= bsum_nxt;
      bdsq_r    <= bdsq_nxt;
      blocks_r  <= blocks_nxt;
      sum_m_r   <= sum_m_nxt;
      sumsq_m_r <= sumsq_m_nxt;
      sum_d_r   <= sum_d_nxt;
      sumsq_d_r <= sumsq_d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    m_r         <= m_nxt;
    q_r         <= q_nxt;
    v_r         <= v_nxt;
    res_mean_r  <= res_mean_nxt;
    res_merr_r  <= res_merr_nxt;
    res_dmean_r <= res_dmean_nxt;
    res_derr_r  <= res_derr_nxt;
    if (out_load) begin
      out_index_r <= blocks_r - 1'b1;
      out_mean_r  <= res_mean_r;
      out_merr_r  <= res_merr_r;
      out_dmean_r <= res_dmean_r;
      out_derr_r  <= res_derr_r;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_block_index            = out_index_r;
  assign out_progressive_mean       = out_mean_r;
  assign out_mean_error             = out_merr_r;
  assign out_progressive_devsq_mean = out_dmean_r;
  assign out_devsq_error            = out_derr_r;

endmodule

// File: design/bae_iter_unit.sv
// ============================================================================
// bae_iter_unit: shared iterative divide and square root unit
// A restoring divider that retires one quotient bit per cycle, and a
// digit-by-digit square root that retires one root bit per cycle, both
// built around one compare and subtract.
// ============================================================================
module bae_iter_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int DIV_W       = 48,
  parameter int DVSR_W      = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bae_pkg::iter_ctrl_t    ctrl,
  input  logic [DIV_W-1:0]       dividend,
  input  logic [DVSR_W-1:0]      divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quotient,
  output logic [SAMPLE_BITS-1:0] root
);
  import bae_pkg::*;

  localparam int RW = ((DVSR_W > SAMPLE_BITS) ? DVSR_W : SAMPLE_BITS) + 2;
  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]       op_r, op_nxt;
  logic [RW-1:0]          rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] root_r, root_nxt;
  logic [DVSR_W-1:0]      dvsr_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r, done_r;
  op_t                    mode_r;

  logic [RW-1:0] cand, trial, diff;
  logic          ge;

  always_comb begin
    if (mode_r == OP_SQRT) begin
      cand  = {rem_r[RW-3:0], op_r[DIV_W-1:DIV_W-2]};
      trial = RW'({root_r, 2'b01});
    end else begin
      cand  = {rem_r[RW-2:0], op_r[DIV_W-1]};
      trial = RW'(dvsr_r);
    end
    ge      = (cand >= trial);
    diff    = cand - trial;
    rem_nxt = ge ? diff : cand;
    if (mode_r == OP_SQRT) begin
      op_nxt   = {op_r[DIV_W-3:0], 2'b00};
      root_nxt = {root_r[SAMPLE_BITS-2:0], ge};
    end else begin
      op_nxt   = {op_r[DIV_W-2:0], ge};
      root_nxt = root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (ctrl.op == OP_SQRT) ? CW'(SAMPLE_BITS) : CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op_r   <= dividend;
      rem_r  <= '0;
      root_r <= '0;
      dvsr_r <= divisor;
      mode_r <= ctrl.op;
    end else if (busy_r) begin
      op_r   <= op_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = op_r;
  assign root     = root_r;

endmodule
